// ===== src/cch_pkg.sv =====
// Shared constants, item codes, store command types and the saturating increment for the class histogram.
package cch_pkg;

   localparam int CLASS_COUNT = 16;
   localparam int VALUE_BINS  = 256;
   localparam int COUNT_BITS  = 24;
   localparam int OUT_BITS    = 24;

   localparam int LABEL_BITS    = 8;
   localparam int VALUE_BITS    = 8;
   localparam int MODE_BITS     = 2;
   localparam int CLASS_BITS    = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
   localparam int BIN_ADDR_BITS = CLASS_BITS + VALUE_BITS;
   localparam int BIN_DEPTH     = CLASS_COUNT * VALUE_BINS;

   localparam logic [LABEL_BITS:0]   LABEL_LIMIT = (LABEL_BITS + 1)'(CLASS_COUNT);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};

   // Item modes
   localparam logic [MODE_BITS-1:0] MODE_ACCUM     = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_READ      = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_READ_CLR  = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_CLR_TOTAL = 2'd3;

   typedef logic [COUNT_BITS-1:0]    count_type;
   typedef logic [BIN_ADDR_BITS-1:0] bin_addr_type;
   typedef logic [CLASS_BITS-1:0]    class_addr_type;

   // Write command into the histogram store
   typedef struct packed {
      logic           bin_we;
      bin_addr_type   bin_addr;
      count_type      bin_data;
      logic           tot_we;
      class_addr_type tot_addr;
      count_type      tot_data;
   } store_wr_type;

   // Increment, holding at full scale
   function automatic count_type sat_inc(input count_type v);
      sat_inc = (v == COUNT_MAX) ? v : v + count_type'(1);
   endfunction

endpackage

// ===== src/cch_store.sv =====
// Bin count and class total memories with the post-reset clearing sweep.
module cch_store (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  cch_pkg::bin_addr_type   rd_bin_addr,
   input  cch_pkg::class_addr_type rd_tot_addr,
   input  cch_pkg::store_wr_type   wr,
   output cch_pkg::count_type      bin_rd,
   output cch_pkg::count_type      tot_rd,
   output logic                    ready
);
   import cch_pkg::*;

   count_type    bin_mem [0:BIN_DEPTH-1];
   count_type    tot_mem [0:CLASS_COUNT-1];
   count_type    bin_rd_ff;
   count_type    tot_rd_ff;
   logic         clr_busy_ff;
   logic         clr_busy_in;
   bin_addr_type clr_addr_ff;
   bin_addr_type clr_addr_in;

   // Advance the clearing sweep, one bin per cycle
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + bin_addr_type'(1);
         if (clr_addr_ff == bin_addr_type'(BIN_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Bin memory: sweep writes zero, otherwise take the item write
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         bin_mem[clr_addr_ff] <= '0;
      end else if (wr.bin_we) begin
         bin_mem[wr.bin_addr] <= wr.bin_data;
      end
      if (rd_en) begin
         bin_rd_ff <= bin_mem[rd_bin_addr];
      end
   end

   // Total memory: the sweep covers it through the low address bits
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         tot_mem[clr_addr_ff[CLASS_BITS-1:0]] <= '0;
      end else if (wr.tot_we) begin
         tot_mem[wr.tot_addr] <= wr.tot_data;
      end
      if (rd_en) begin
         tot_rd_ff <= tot_mem[rd_tot_addr];
      end
   end

   assign bin_rd = bin_rd_ff;
   assign tot_rd = tot_rd_ff;
   assign ready  = !clr_busy_ff;

endmodule

// ===== src/class_conditioned_histogram.sv =====
// Per-class histogram of 8-bit pixel values with saturating bin counts and class totals.
// Each item is read from the store in the cycle it is accepted and written
// back from the write-back state that follows, so an item never overlaps the
// write of the one before it. A result waits in the output register; the
// next item is taken while it waits, and only an item that itself produces
// a result holds in the write-back cycle until the output register frees.
// After reset the block runs a clearing sweep over all CLASS_COUNT * 256 bins
// (4096 at 16 classes) of the bin memory, clearing the class totals on
// the way, and accepts no item until the sweep ends. Labels at or above
// CLASS_COUNT change nothing and return a result with label_ignored set.
module class_conditioned_histogram (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cch_pkg::MODE_BITS-1:0]   req_mode,
   input  logic [cch_pkg::LABEL_BITS-1:0]  req_class_label,
   input  logic [cch_pkg::VALUE_BITS-1:0]  req_pixel_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [cch_pkg::OUT_BITS-1:0]    rsp_bin_count,
   output logic [cch_pkg::OUT_BITS-1:0]    rsp_class_total,
   output logic                            rsp_label_ignored
);
   import cch_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RMW  = 1'b1;

   logic                  state_ff;
   logic                  state_in;
   logic [MODE_BITS-1:0]  mode_ff;
   logic [CLASS_BITS-1:0] class_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  ign_ff;
   logic                  req_ign;
   logic                  accept;
   logic                  produce;
   logic                  leave;
   logic                  store_ready;
   count_type             bin_rd;
   count_type             tot_rd;
   store_wr_type          wr;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [OUT_BITS-1:0]   rsp_bin_ff;
   logic [OUT_BITS-1:0]   rsp_tot_ff;
   logic                  rsp_ign_ff;

   assign req_ign   = ({1'b0, req_class_label} >= LABEL_LIMIT);
   assign req_ready = (state_ff == ST_IDLE) && store_ready;
   assign accept    = req_valid && req_ready;

   // Read both stores in the accept cycle
   cch_store u_store (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (accept),
      .rd_bin_addr ({req_class_label[CLASS_BITS-1:0], req_pixel_value}),
      .rd_tot_addr (req_class_label[CLASS_BITS-1:0]),
      .wr          (wr),
      .bin_rd      (bin_rd),
      .tot_rd      (tot_rd),
      .ready       (store_ready)
   );

   // Hold the item fields across the read
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         class_ff <= req_class_label[CLASS_BITS-1:0];
         value_ff <= req_pixel_value;
         ign_ff   <= req_ign;
      end
   end

   // Leave the write-back cycle unless a result has nowhere to go
   assign produce = ign_ff || (mode_ff != MODE_ACCUM);
   assign leave   = !produce || !rsp_valid_ff || rsp_ready;

   // Build the write-back command
   always_comb begin
      wr          = '0;
      wr.bin_addr = {class_ff, value_ff};
      wr.tot_addr = class_ff;
      if ((state_ff == ST_RMW) && leave && !ign_ff) begin
         case (mode_ff)
            MODE_ACCUM: begin
               wr.bin_we   = 1'b1;
               wr.bin_data = sat_inc(bin_rd);
               wr.tot_we   = 1'b1;
               wr.tot_data = sat_inc(tot_rd);
            end
            MODE_READ_CLR: begin
               wr.bin_we = 1'b1;
            end
            MODE_CLR_TOTAL: begin
               wr.tot_we = 1'b1;
            end
            default: begin
               wr.bin_we = 1'b0;
            end
         endcase
      end
   end

   // Sequence the item
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RMW;
            end
         end
         ST_RMW: begin
            if (leave) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if ((state_ff == ST_RMW) && leave && produce) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the output register with the values before any clear
   always_ff @(posedge clock) begin
      if ((state_ff == ST_RMW) && leave && produce) begin
         rsp_ign_ff <= ign_ff;
         if (ign_ff || (mode_ff == MODE_CLR_TOTAL)) begin
            rsp_bin_ff <= '0;
         end else begin
            rsp_bin_ff <= OUT_BITS'(bin_rd);
         end
         if (ign_ff) begin
            rsp_tot_ff <= '0;
         end else begin
            rsp_tot_ff <= OUT_BITS'(tot_rd);
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bin_count     = rsp_bin_ff;
   assign rsp_class_total   = rsp_tot_ff;
   assign rsp_label_ignored = rsp_ign_ff;

   // An accepted item goes to write-back next cycle
   a_accept_rmw: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RMW))
      else $error("accepted item did not enter write-back");

   // A result-producing item leaves write-back with a valid result
   a_result_out: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RMW) && leave && produce) |=> rsp_valid_ff)
      else $error("result lost on leaving write-back");

   // An out-of-range label never writes either store
   a_ign_no_write: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RMW) && ign_ff) |-> (!wr.bin_we && !wr.tot_we))
      else $error("ignored label wrote a store");

   // A saturating increment never wraps to zero
   a_no_wrap: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RMW) && (mode_ff == MODE_ACCUM) && wr.bin_we)
      |-> ((wr.bin_data != '0) && (wr.tot_data != '0)))
      else $error("counter wrapped");

endmodule

// ===== test/class_conditioned_histogram_tb.sv =====
// Self-checking testbench for the class-conditioned pixel histogram.
`timescale 1ns / 1ps

module class_conditioned_histogram_tb;
   import cch_pkg::*;

   localparam int CYCLE_LIMIT      = 400_000;
   localparam int DRAIN_CYCLES     = 16;
   localparam int RANDOM_PER_PHASE = 470;
   localparam int PHASE_COUNT      = 4;
   localparam int DIRECTED_COUNT   = 25;

   typedef struct packed {
      logic [OUT_BITS-1:0] bin_count;
      logic [OUT_BITS-1:0] class_total;
      logic                label_ignored;
   } readout_type;

   typedef struct packed {
      logic [MODE_BITS-1:0]  op;
      logic [LABEL_BITS-1:0] label;
      logic [VALUE_BITS-1:0] pixel;
      logic                  typed;
      readout_type           want;
   } directed_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [MODE_BITS-1:0]  req_mode = MODE_ACCUM;
   logic [LABEL_BITS-1:0] req_class_label = '0;
   logic [VALUE_BITS-1:0] req_pixel_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [OUT_BITS-1:0] rsp_bin_count;
   logic [OUT_BITS-1:0] rsp_class_total;
   logic rsp_label_ignored;

   // Histogram image kept by the testbench
   count_type bin_image [BIN_DEPTH];
   count_type total_image [CLASS_COUNT];

   readout_type pending_readouts [$];
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int cycle_count;

   // Directed items: fixed readouts where they are obvious, else predicted
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{MODE_READ,      8'd0,   8'd0,   1'b1, '{24'd0, 24'd0, 1'b0}},
      '{MODE_READ,      8'd15,  8'd255, 1'b1, '{24'd0, 24'd0, 1'b0}},
      '{MODE_CLR_TOTAL, 8'd15,  8'd0,   1'b1, '{24'd0, 24'd0, 1'b0}},
      '{MODE_READ,      8'd16,  8'd0,   1'b1, '{24'd0, 24'd0, 1'b1}},
      '{MODE_ACCUM,     8'd255, 8'd255, 1'b1, '{24'd0, 24'd0, 1'b1}},
      '{MODE_READ_CLR,  8'd200, 8'd17,  1'b1, '{24'd0, 24'd0, 1'b1}},
      '{MODE_CLR_TOTAL, 8'd128, 8'd3,   1'b1, '{24'd0, 24'd0, 1'b1}},
      '{MODE_ACCUM,     8'd0,   8'd0,   1'b0, '0},
      '{MODE_ACCUM,     8'd0,   8'd0,   1'b0, '0},
      '{MODE_ACCUM,     8'd0,   8'd255, 1'b0, '0},
      '{MODE_ACCUM,     8'd15,  8'd255, 1'b0, '0},
      '{MODE_ACCUM,     8'd15,  8'd255, 1'b0, '0},
      '{MODE_READ,      8'd0,   8'd0,   1'b0, '0},
      '{MODE_READ,      8'd15,  8'd255, 1'b0, '0},
      '{MODE_READ_CLR,  8'd0,   8'd0,   1'b0, '0},
      '{MODE_READ,      8'd0,   8'd0,   1'b0, '0},
      '{MODE_CLR_TOTAL, 8'd0,   8'd170, 1'b0, '0},
      '{MODE_READ,      8'd0,   8'd255, 1'b0, '0},
      '{MODE_ACCUM,     8'd0,   8'd255, 1'b0, '0},
      '{MODE_READ,      8'd0,   8'd255, 1'b0, '0},
      '{MODE_ACCUM,     8'd7,   8'd85,  1'b0, '0},
      '{MODE_ACCUM,     8'd7,   8'd85,  1'b0, '0},
      '{MODE_READ_CLR,  8'd7,   8'd85,  1'b0, '0},
      '{MODE_READ_CLR,  8'd7,   8'd85,  1'b0, '0},
      '{MODE_CLR_TOTAL, 8'd15,  8'd0,   1'b0, '0}
   };

   class_conditioned_histogram u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_class_label   (req_class_label),
      .req_pixel_value   (req_pixel_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_bin_count     (rsp_bin_count),
      .rsp_class_total   (rsp_class_total),
      .rsp_label_ignored (rsp_label_ignored)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Advance the histogram image by one item; return 1 when it yields a readout
   function automatic logic histogram_apply(input logic [MODE_BITS-1:0] op,
                                            input logic [LABEL_BITS-1:0] label,
                                            input logic [VALUE_BITS-1:0] pixel,
                                            output readout_type r);
      int idx;
      count_type bin;
      count_type total;
      r = '0;
      if (int'(label) >= CLASS_COUNT) begin
         r.label_ignored = 1'b1;
         return 1'b1;
      end
      idx = int'(label) * VALUE_BINS + int'(pixel);
      bin = bin_image[idx];
      total = total_image[label];
      case (op)
         MODE_ACCUM: begin
            bin_image[idx] = (bin == COUNT_MAX) ? bin : bin + count_type'(1);
            total_image[label] = (total == COUNT_MAX) ? total : total + count_type'(1);
            return 1'b0;
         end
         MODE_READ: begin
            r.bin_count = OUT_BITS'(bin);
            r.class_total = OUT_BITS'(total);
         end
         MODE_READ_CLR: begin
            r.bin_count = OUT_BITS'(bin);
            r.class_total = OUT_BITS'(total);
            bin_image[idx] = '0;
         end
         default: begin
            r.class_total = OUT_BITS'(total);
            total_image[label] = '0;
         end
      endcase
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Present one item, hold it until taken, then record what it should return
   task automatic drive_item(input logic [MODE_BITS-1:0] op,
                             input logic [LABEL_BITS-1:0] label,
                             input logic [VALUE_BITS-1:0] pixel,
                             input logic typed,
                             input readout_type want);
      readout_type predicted;
      logic yields;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= op;
      req_class_label <= label;
      req_pixel_value <= pixel;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      yields = histogram_apply(op, label, pixel, predicted);
      if (typed)
         pending_readouts.push_back(want);
      else if (yields)
         pending_readouts.push_back(predicted);
   endtask

   // Pick a random item, biased toward a few hot bins so counts build up
   task automatic pick_random(output logic [MODE_BITS-1:0] op,
                              output logic [LABEL_BITS-1:0] label,
                              output logic [VALUE_BITS-1:0] pixel);
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) op = MODE_ACCUM;
      else if (r < 80) op = MODE_READ;
      else if (r < 92) op = MODE_READ_CLR;
      else op = MODE_CLR_TOTAL;
      r = $urandom_range(0, 99);
      if (r < 10) label = LABEL_BITS'($urandom_range(CLASS_COUNT, 255));
      else if (r < 25) label = LABEL_BITS'($urandom_range(0, 255));
      else if (r < 60) label = LABEL_BITS'($urandom_range(0, 2));
      else if (r < 65) label = LABEL_BITS'(CLASS_COUNT - 1);
      else label = LABEL_BITS'($urandom_range(0, CLASS_COUNT - 1));
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
         0: pixel = 8'd0;
         1: pixel = 8'd1;
         2: pixel = 8'd128;
         default: pixel = 8'd255;
      endcase
      if (r >= 50) pixel = VALUE_BITS'($urandom_range(0, 255));
   endtask

   // Stall the result channel at the current rate
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Check each taken readout against the oldest pending one
   always @(posedge clock) begin
      readout_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readouts.size() == 0) begin
            report_mismatch($sformatf("unexpected readout bin=%0d total=%0d ignored=%0b",
                                      rsp_bin_count, rsp_class_total, rsp_label_ignored));
         end else begin
            want = pending_readouts.pop_front();
            if (rsp_bin_count !== want.bin_count)
               report_mismatch($sformatf("bin_count got %0d want %0d",
                                         rsp_bin_count, want.bin_count));
            if (rsp_class_total !== want.class_total)
               report_mismatch($sformatf("class_total got %0d want %0d",
                                         rsp_class_total, want.class_total));
            if (rsp_label_ignored !== want.label_ignored)
               report_mismatch($sformatf("label_ignored got %0b want %0b",
                                         rsp_label_ignored, want.label_ignored));
         end
      end
   end

   // Watchdog over the whole run, clearing sweep included
   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
         @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Stimulus: directed rows, then random phases with different idling
   initial begin
      int phase_send_idle [PHASE_COUNT] = '{0, 45, 0, 6};
      int phase_rsp_stall [PHASE_COUNT] = '{0, 0, 45, 6};
      logic [MODE_BITS-1:0]  op;
      logic [LABEL_BITS-1:0] label;
      logic [VALUE_BITS-1:0] pixel;
      foreach (bin_image[i]) bin_image[i] = '0;
      foreach (total_image[i]) total_image[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Back-to-back with no idling, so read-after-write hazards are hit
      foreach (directed_rows[i])
         drive_item(directed_rows[i].op, directed_rows[i].label, directed_rows[i].pixel,
                    directed_rows[i].typed, directed_rows[i].want);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         // Hold the sender until every readout is back
         req_valid <= 1'b0;
         @(posedge clock);
         while (pending_readouts.size() != 0) @(posedge clock);
         send_idle_pct = phase_send_idle[p];
         rsp_stall_pct = phase_rsp_stall[p];
         repeat (RANDOM_PER_PHASE) begin
            pick_random(op, label, pixel);
            drive_item(op, label, pixel, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      while (pending_readouts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
